### hw/rtl/cbc_pkg.sv
// ----------------------------------------------------------------------------
// cbc_pkg: shared types and constants of the colour blob centroid block
// Pixel and result item layouts, configuration register indexes, frame
// summary record and the state encoding of the division sequencer.
// ----------------------------------------------------------------------------
package cbc_pkg;

	localparam int LEVEL_W  = 8;
	localparam int LWIDTH_W = 11;
	localparam int COUNT_W  = 21;
	localparam int SUM_W    = 31;
	localparam int CENTER_W = 10;
	localparam int CFG_IDX_W = 2;

	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
	localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};
	localparam logic [CENTER_W-1:0] CENTER_MAX = {CENTER_W{1'b1}};

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_BLUE_MIN   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GREEN_MAX  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RED_MAX    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH = 2'd3;

	localparam logic [LEVEL_W-1:0]  BLUE_MIN_RST   = 8'd150;
	localparam logic [LEVEL_W-1:0]  GREEN_MAX_RST  = 8'd100;
	localparam logic [LEVEL_W-1:0]  RED_MAX_RST    = 8'd100;
	localparam logic [LWIDTH_W-1:0] LINE_WIDTH_RST = 11'd640;

	// One quotient bit per step
	localparam int DIV_STEPS = SUM_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	typedef struct packed {
		logic [LEVEL_W-1:0] blue_level;
		logic [LEVEL_W-1:0] green_level;
		logic [LEVEL_W-1:0] red_level;
		logic               frame_end;
	} pixel_t;

	typedef struct packed {
		logic [CENTER_W-1:0] center_x;
		logic [CENTER_W-1:0] center_y;
		logic [COUNT_W-1:0]  match_count;
		logic                found;
	} result_t;

	typedef struct packed {
		logic [LEVEL_W-1:0]  blue_min;
		logic [LEVEL_W-1:0]  green_max;
		logic [LEVEL_W-1:0]  red_max;
		logic [LWIDTH_W-1:0] line_width;
	} cfg_t;

	typedef struct packed {
		logic [COUNT_W-1:0] hit_count;
		logic [SUM_W-1:0]   column_sum;
		logic [SUM_W-1:0]   row_sum;
	} frame_sum_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_DONE
	} back_state_t;

endpackage

### hw/rtl/color_blob_centroid.sv
// ----------------------------------------------------------------------------
// color_blob_centroid: colour threshold blob centroid over a raster frame
// Top level: configuration registers, accumulating front, summary queue and
// centroid division back end.
// ----------------------------------------------------------------------------
// Usage
// Pixels enter on the pix channel in raster order, one item per clock at
// most, with frame_end set on the last pixel of each frame. A pixel matches
// when its blue level exceeds blue_min and its green and red levels are
// below green_max and red_max. At the end of a frame one result item leaves
// on the res channel with the truncated mean column and row of the matching
// pixels, their count and a found flag; no other pixel produces a result.
// Throughput is one pixel per cycle while pix_stall is low. If the divider
// is free, the summary enters the queue at the edge accepting the last
// pixel, then the divider loads from the queue, runs bit-serially and the
// result register loads. Summaries of up to two finished frames wait in
// the queue while the divider is busy; only when it is full does pix_stall
// rise. A stalled result holds in the output register and the divider
// halts with the next centroid until the register frees. Reset restores
// the default thresholds and line width of 640 and clears positions, sums
// and queue. Configuration is written through cfg_we, cfg_index and
// cfg_data while the block is idle, a rule on the user that is not enforced.
// ----------------------------------------------------------------------------
module color_blob_centroid #(
	parameter int MAX_LINE = 1024,
	parameter int MAX_ROWS = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [cbc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [cbc_pkg::LWIDTH_W-1:0]      cfg_data,
	input  cbc_pkg::pixel_t                   pix,
	input  logic                              pix_valid,
	output logic                              pix_stall,
	output cbc_pkg::result_t                  res,
	output logic                              res_valid,
	input  logic                              res_stall
);

	cbc_pkg::cfg_t       cfg_q;
	cbc_pkg::q_status_t  q_stat;
	cbc_pkg::frame_sum_t push_data;
	cbc_pkg::frame_sum_t pop_data;
	logic                push;
	logic                pop;

	// Configuration registers; every index of the port maps to one register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.blue_min   <= cbc_pkg::BLUE_MIN_RST;
			cfg_q.green_max  <= cbc_pkg::GREEN_MAX_RST;
			cfg_q.red_max    <= cbc_pkg::RED_MAX_RST;
			cfg_q.line_width <= cbc_pkg::LINE_WIDTH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cbc_pkg::CFG_BLUE_MIN:   cfg_q.blue_min   <= cfg_data[cbc_pkg::LEVEL_W-1:0];
				cbc_pkg::CFG_GREEN_MAX:  cfg_q.green_max  <= cfg_data[cbc_pkg::LEVEL_W-1:0];
				cbc_pkg::CFG_RED_MAX:    cfg_q.red_max    <= cfg_data[cbc_pkg::LEVEL_W-1:0];
				cbc_pkg::CFG_LINE_WIDTH: cfg_q.line_width <= cfg_data;
				default: ;
			endcase
		end
	end

	// The front keeps counting pixels of the next frame while the back end
	// is still dividing the previous one.
	cbc_front #(
		.MAX_LINE(MAX_LINE),
		.MAX_ROWS(MAX_ROWS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.pix      (pix),
		.pix_valid(pix_valid),
		.pix_stall(pix_stall),
		.q_stat   (q_stat),
		.push     (push),
		.push_data(push_data)
	);

	cbc_queue #(
		.DEPTH(2)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.pop_data (pop_data),
		.stat     (q_stat)
	);

	cbc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_data (pop_data),
		.q_stat   (q_stat),
		.pop      (pop),
		.res      (res),
		.res_valid(res_valid),
		.res_stall(res_stall)
	);

endmodule

### hw/rtl/cbc_front.sv
// ----------------------------------------------------------------------------
// cbc_front: pixel classification and frame accumulation
// Tests each pixel against the thresholds, tracks the raster position and
// keeps the saturating count and coordinate sums. Hands a summary record to
// the queue on the last pixel of a frame and clears for the next one.
// ----------------------------------------------------------------------------
module cbc_front #(
	parameter int MAX_LINE = 1024,
	parameter int MAX_ROWS = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cbc_pkg::cfg_t       cfg,
	input  cbc_pkg::pixel_t     pix,
	input  logic                pix_valid,
	output logic                pix_stall,
	input  cbc_pkg::q_status_t  q_stat,
	output logic                push,
	output cbc_pkg::frame_sum_t push_data
);

	localparam int CW = $clog2(MAX_LINE);
	localparam int RW = $clog2(MAX_ROWS);
	localparam int WW = (CW + 1 > cbc_pkg::LWIDTH_W) ? CW + 1 : cbc_pkg::LWIDTH_W;

	logic [CW-1:0]               col_q;
	logic [RW-1:0]               row_q;
	logic [cbc_pkg::COUNT_W-1:0] cnt_q;
	logic [cbc_pkg::SUM_W-1:0]   col_sum_q;
	logic [cbc_pkg::SUM_W-1:0]   row_sum_q;

	logic                        acc;
	logic                        match;
	logic [cbc_pkg::COUNT_W-1:0] cnt_nx;
	logic [cbc_pkg::SUM_W-1:0]   col_sum_nx;
	logic [cbc_pkg::SUM_W-1:0]   row_sum_nx;
	logic [cbc_pkg::SUM_W:0]     col_add;
	logic [cbc_pkg::SUM_W:0]     row_add;
	logic [WW-1:0]               lw_ext;
	logic [WW-1:0]               w_eff;
	logic                        row_wrap;

	// The queue only fills if frames end faster than the divider drains them.
	assign pix_stall = q_stat.full;
	assign acc       = pix_valid && !pix_stall;

	assign match = (pix.blue_level > cfg.blue_min) && (pix.green_level < cfg.green_max)
		&& (pix.red_level < cfg.red_max);

	assign col_add = {1'b0, col_sum_q} + (cbc_pkg::SUM_W + 1)'(col_q);
	assign row_add = {1'b0, row_sum_q} + (cbc_pkg::SUM_W + 1)'(row_q);

	always_comb begin
		cnt_nx     = cnt_q;
		col_sum_nx = col_sum_q;
		row_sum_nx = row_sum_q;
		if (match) begin
			cnt_nx     = (cnt_q == cbc_pkg::COUNT_MAX) ? cnt_q : cnt_q + 1'b1;
			col_sum_nx = col_add[cbc_pkg::SUM_W] ? cbc_pkg::SUM_MAX
				: col_add[cbc_pkg::SUM_W-1:0];
			row_sum_nx = row_add[cbc_pkg::SUM_W] ? cbc_pkg::SUM_MAX
				: row_add[cbc_pkg::SUM_W-1:0];
		end
	end

	// Effective line width, clamped to 1 .. MAX_LINE
	assign lw_ext = WW'(cfg.line_width);
	always_comb begin
		priority if (lw_ext == '0) begin
			w_eff = WW'(1);
		end else if (lw_ext > WW'(MAX_LINE)) begin
			w_eff = WW'(MAX_LINE);
		end else begin
			w_eff = lw_ext;
		end
	end

	assign row_wrap = (WW'(col_q) + WW'(1)) >= w_eff;

	assign push                 = acc && pix.frame_end;
	assign push_data.hit_count  = cnt_nx;
	assign push_data.column_sum = col_sum_nx;
	assign push_data.row_sum    = row_sum_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_q     <= '0;
			cnt_q     <= '0;
			col_sum_q <= '0;
			row_sum_q <= '0;
		end else if (acc) begin
			if (pix.frame_end) begin
				col_q     <= '0;
				row_q     <= '0;
				cnt_q     <= '0;
				col_sum_q <= '0;
				row_sum_q <= '0;
			end else begin
				cnt_q     <= cnt_nx;
				col_sum_q <= col_sum_nx;
				row_sum_q <= row_sum_nx;
				if (row_wrap) begin
					col_q <= '0;
					if (row_q != RW'(MAX_ROWS - 1)) begin
						row_q <= row_q + 1'b1;
					end
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

	a_clear_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> (cnt_q == '0) && (col_q == '0) && (row_q == '0))
		else $error("frame state not cleared after last pixel");

	a_column_in_line: assert property (@(posedge clk) disable iff (!arst_n)
		(CW + 1)'(col_q) < (CW + 1)'(MAX_LINE))
		else $error("column position beyond maximum line");

endmodule

### hw/rtl/cbc_queue.sv
// ----------------------------------------------------------------------------
// cbc_queue: short queue of frame summary records
// Decouples the accumulating front from the division back end.
// ----------------------------------------------------------------------------
module cbc_queue #(
	parameter int DEPTH = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  cbc_pkg::frame_sum_t push_data,
	input  logic                pop,
	output cbc_pkg::frame_sum_t pop_data,
	output cbc_pkg::q_status_t  stat
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	cbc_pkg::frame_sum_t entry_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [NW-1:0] fill_q;

	assign stat.full  = (fill_q == NW'(DEPTH));
	assign stat.empty = (fill_q == '0);
	assign pop_data   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && stat.full) && !(pop && stat.empty))
		else $error("queue pushed when full or popped when empty");

endmodule

### hw/rtl/cbc_back.sv
// ----------------------------------------------------------------------------
// cbc_back: centroid division and result register
// Takes one frame summary, divides both coordinate sums by the count with a
// pair of restoring dividers (one quotient bit per cycle) and loads the
// saturated centroid into the result register.
// ----------------------------------------------------------------------------
module cbc_back (
	input  logic                clk,
	input  logic                arst_n,
	input  cbc_pkg::frame_sum_t pop_data,
	input  cbc_pkg::q_status_t  q_stat,
	output logic                pop,
	output cbc_pkg::result_t    res,
	output logic                res_valid,
	input  logic                res_stall
);

	cbc_pkg::back_state_t state_q;
	cbc_pkg::back_state_t state_nx;

	logic [cbc_pkg::DIV_CNT_W-1:0] step_q;
	logic [cbc_pkg::COUNT_W-1:0]   div_q;
	logic [cbc_pkg::SUM_W-1:0]     num_x_q;
	logic [cbc_pkg::SUM_W-1:0]     num_y_q;
	logic [cbc_pkg::COUNT_W-1:0]   rem_x_q;
	logic [cbc_pkg::COUNT_W-1:0]   rem_y_q;
	cbc_pkg::result_t              res_q;
	logic                          res_valid_q;

	logic load_en;
	logic step_en;
	logic res_load;
	logic res_room;

	logic [cbc_pkg::COUNT_W:0] sh_x;
	logic [cbc_pkg::COUNT_W:0] sh_y;
	logic [cbc_pkg::COUNT_W:0] diff_x;
	logic [cbc_pkg::COUNT_W:0] diff_y;
	logic                      qbit_x;
	logic                      qbit_y;
	logic                      found;

	assign res_room = !res_valid_q || !res_stall;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			cbc_pkg::BK_IDLE: begin
				if (!q_stat.empty) state_nx = cbc_pkg::BK_DIV;
			end
			cbc_pkg::BK_DIV: begin
				if (step_q == cbc_pkg::DIV_CNT_W'(cbc_pkg::DIV_STEPS - 1)) begin
					state_nx = cbc_pkg::BK_DONE;
				end
			end
			cbc_pkg::BK_DONE: begin
				if (res_room) state_nx = cbc_pkg::BK_IDLE;
			end
			default: state_nx = cbc_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		load_en  = 1'b0;
		step_en  = 1'b0;
		res_load = 1'b0;
		unique case (state_q)
			cbc_pkg::BK_IDLE: load_en  = !q_stat.empty;
			cbc_pkg::BK_DIV:  step_en  = 1'b1;
			cbc_pkg::BK_DONE: res_load = res_room;
			default: ;
		endcase
	end

	assign pop = load_en;

	// Restoring division step for both coordinates
	assign sh_x   = {rem_x_q, num_x_q[cbc_pkg::SUM_W-1]};
	assign sh_y   = {rem_y_q, num_y_q[cbc_pkg::SUM_W-1]};
	assign diff_x = sh_x - {1'b0, div_q};
	assign diff_y = sh_y - {1'b0, div_q};
	assign qbit_x = sh_x >= {1'b0, div_q};
	assign qbit_y = sh_y >= {1'b0, div_q};

	assign found = (div_q != '0);

	always_ff @(posedge clk) begin
		if (load_en) begin
			div_q   <= pop_data.hit_count;
			num_x_q <= pop_data.column_sum;
			num_y_q <= pop_data.row_sum;
			rem_x_q <= '0;
			rem_y_q <= '0;
		end else if (step_en) begin
			rem_x_q <= qbit_x ? diff_x[cbc_pkg::COUNT_W-1:0] : sh_x[cbc_pkg::COUNT_W-1:0];
			rem_y_q <= qbit_y ? diff_y[cbc_pkg::COUNT_W-1:0] : sh_y[cbc_pkg::COUNT_W-1:0];
			num_x_q <= {num_x_q[cbc_pkg::SUM_W-2:0], qbit_x};
			num_y_q <= {num_y_q[cbc_pkg::SUM_W-2:0], qbit_y};
		end
		if (res_load) begin
			res_q.found       <= found;
			res_q.match_count <= div_q;
			if (!found) begin
				res_q.center_x <= '0;
				res_q.center_y <= '0;
			end else begin
				res_q.center_x <= (|num_x_q[cbc_pkg::SUM_W-1:cbc_pkg::CENTER_W])
					? cbc_pkg::CENTER_MAX : num_x_q[cbc_pkg::CENTER_W-1:0];
				res_q.center_y <= (|num_y_q[cbc_pkg::SUM_W-1:cbc_pkg::CENTER_W])
					? cbc_pkg::CENTER_MAX : num_y_q[cbc_pkg::CENTER_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cbc_pkg::BK_IDLE;
			step_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (load_en) begin
				step_q <= '0;
			end else if (step_en) begin
				step_q <= step_q + 1'b1;
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res       = res_q;
	assign res_valid = res_valid_q;

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> (state_q == cbc_pkg::BK_DONE)
			&& ($past(state_q) == cbc_pkg::BK_DIV || $past(state_q) == cbc_pkg::BK_DONE))
		else $error("result loaded outside the end of a division");

	a_empty_frame_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res.found) |-> (res.center_x == '0) && (res.center_y == '0)
			&& (res.match_count == '0))
		else $error("frame without matches reports a centroid");

endmodule

### test/color_blob_centroid_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// color_blob_centroid_tb: self-checking bench for the colour blob centroid
// Pixel items are sent through a valid/stall handshake with random gaps, and
// result items are taken with random stalls. A behavioural tracker of the
// thresholds, positions and sums predicts each frame's centroid, and every
// result is compared field by field with the oldest prediction. A short
// scripted table comes first, then a frame one pixel wide, then random
// frames under random register settings.
// ----------------------------------------------------------------------------
module color_blob_centroid_tb;

	localparam int MAX_LINE     = 1024;
	localparam int MAX_ROWS     = 1024;
	localparam int DRAIN_CYCLES = 40;
	// No accepted item for this long means the block has hung.
	localparam int QUIET_LIMIT  = 1000;
	localparam int RANDOM_PIXELS = 415;

	typedef enum logic {
		STEP_PIXEL,
		STEP_WRITE
	} step_kind_t;

	// One line of the scripted opening: either a pixel item or a register
	// write. A typed result, where given, replaces the tracker's prediction.
	typedef struct {
		step_kind_t                         kind;
		cbc_pkg::pixel_t                    px;
		logic [cbc_pkg::CFG_IDX_W-1:0]      reg_idx;
		logic [cbc_pkg::LWIDTH_W-1:0]       reg_val;
		bit                                 typed;
		cbc_pkg::result_t                   want;
	} script_row_t;

	logic                               clk;
	logic                               arst_n;
	logic                               cfg_we;
	logic [cbc_pkg::CFG_IDX_W-1:0]      cfg_index;
	logic [cbc_pkg::LWIDTH_W-1:0]       cfg_data;
	cbc_pkg::pixel_t                    pix;
	logic                               pix_valid;
	logic                               pix_stall;
	cbc_pkg::result_t                   res;
	logic                               res_valid;
	logic                               res_stall = 1'b0;

	// Shadow copy of the registers.
	logic [cbc_pkg::LEVEL_W-1:0]        thr_blue;
	logic [cbc_pkg::LEVEL_W-1:0]        thr_green;
	logic [cbc_pkg::LEVEL_W-1:0]        thr_red;
	logic [cbc_pkg::LWIDTH_W-1:0]       row_len;

	// Shadow copy of the frame accumulators.
	int                                 col_at;
	int                                 row_at;
	logic [cbc_pkg::COUNT_W-1:0]        hits;
	longint unsigned                    col_total;
	longint unsigned                    row_total;

	cbc_pkg::result_t                   centroid_due [$];
	int                                 err_count = 0;
	int                                 quiet_cycles = 0;
	int                                 calm_left = 0;
	int                                 stall_left = 0;
	int                                 stall_pick;

	color_blob_centroid #(
		.MAX_LINE (MAX_LINE),
		.MAX_ROWS (MAX_ROWS)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pix       (pix),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.res       (res),
		.res_valid (res_valid),
		.res_stall (res_stall)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Tracker
	// ------------------------------------------------------------------

	function automatic void clear_tracks();
		col_at    = 0;
		row_at    = 0;
		hits      = '0;
		col_total = 0;
		row_total = 0;
	endfunction

	// A width of zero behaves as one, and anything past the longest line is
	// held at the longest line.
	function automatic int line_eff();
		if (row_len == 0)
			return 1;
		if (int'(row_len) > MAX_LINE)
			return MAX_LINE;
		return int'(row_len);
	endfunction

	// Advances the tracker by one accepted pixel. Returns 1 when the pixel
	// closes a frame, with the frame's centroid in r.
	function automatic bit centroid_step(input cbc_pkg::pixel_t p,
	                                     output cbc_pkg::result_t r);
		longint unsigned cx;
		longint unsigned cy;
		r = '0;
		if (p.blue_level > thr_blue && p.green_level < thr_green &&
		    p.red_level < thr_red) begin
			if (hits != cbc_pkg::COUNT_MAX)
				hits = hits + 1'b1;
			col_total = (col_total + col_at > cbc_pkg::SUM_MAX) ? 64'(cbc_pkg::SUM_MAX)
				: col_total + 64'(col_at);
			row_total = (row_total + row_at > cbc_pkg::SUM_MAX) ? 64'(cbc_pkg::SUM_MAX)
				: row_total + 64'(row_at);
		end
		if (p.frame_end) begin
			cx = 0;
			cy = 0;
			if (hits != 0) begin
				cx = col_total / 64'(hits);
				cy = row_total / 64'(hits);
				if (cx > cbc_pkg::CENTER_MAX)
					cx = 64'(cbc_pkg::CENTER_MAX);
				if (cy > cbc_pkg::CENTER_MAX)
					cy = 64'(cbc_pkg::CENTER_MAX);
			end
			r.center_x    = cx[cbc_pkg::CENTER_W-1:0];
			r.center_y    = cy[cbc_pkg::CENTER_W-1:0];
			r.match_count = hits;
			r.found       = (hits != 0);
			clear_tracks();
			return 1'b1;
		end
		// A column at or beyond the end of the line, which happens when the
		// width is lowered in the middle of a frame, wraps to the next row.
		if (col_at + 1 >= line_eff()) begin
			col_at = 0;
			if (row_at + 1 < MAX_ROWS)
				row_at++;
		end else begin
			col_at++;
		end
		return 1'b0;
	endfunction

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------

	task automatic report_mismatch(input string msg);
		$display("ERROR at %0t: %s", $realtime, msg);
		err_count++;
	endtask

	task automatic check_result(input cbc_pkg::result_t got);
		cbc_pkg::result_t want;
		if (centroid_due.size() == 0) begin
			report_mismatch($sformatf("unexpected result x=%0d y=%0d n=%0d found=%0d",
				got.center_x, got.center_y, got.match_count, got.found));
		end else begin
			want = centroid_due.pop_front();
			if (got.center_x !== want.center_x)
				report_mismatch($sformatf("center_x %0d, expected %0d",
					got.center_x, want.center_x));
			if (got.center_y !== want.center_y)
				report_mismatch($sformatf("center_y %0d, expected %0d",
					got.center_y, want.center_y));
			if (got.match_count !== want.match_count)
				report_mismatch($sformatf("match_count %0d, expected %0d",
					got.match_count, want.match_count));
			if (got.found !== want.found)
				report_mismatch($sformatf("found %0d, expected %0d",
					got.found, want.found));
		end
	endtask

	// Result side: take items when offered and stall in spans of random
	// length, mostly short, occasionally long, with stretches of no stall.
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid && !res_stall)
				check_result(res);
			if (stall_left != 0) begin
				stall_left--;
			end else begin
				stall_pick = $urandom_range(0, 19);
				if (stall_pick == 0) begin
					res_stall <= 1'b1;
					stall_left = $urandom_range(10, 40);
				end else if (stall_pick < 8) begin
					res_stall <= 1'b1;
					stall_left = $urandom_range(0, 2);
				end else if (stall_pick < 11) begin
					res_stall <= 1'b0;
					stall_left = $urandom_range(15, 50);
				end else begin
					res_stall <= 1'b0;
					stall_left = $urandom_range(0, 3);
				end
			end
		end
	end

	// Watchdog: a long spell with no item accepted on either side ends
	// the run.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((pix_valid && !pix_stall) || (res_valid && !res_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Watchdog: nothing accepted for %0d cycles", QUIET_LIMIT);
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------

	// Offers one pixel item after a random gap and holds it until taken.
	// The valid line stays high between back-to-back items.
	task automatic send_pixel(input cbc_pkg::pixel_t p, input bit typed,
	                          input cbc_pkg::result_t want);
		int               gap;
		int               pick;
		cbc_pkg::result_t due;
		gap = 0;
		if (calm_left != 0) begin
			calm_left--;
		end else begin
			pick = $urandom_range(0, 99);
			if (pick < 5)
				calm_left = $urandom_range(10, 60);
			else if (pick < 65)
				gap = 0;
			else if (pick < 93)
				gap = $urandom_range(1, 3);
			else
				gap = $urandom_range(8, 40);
		end
		if (gap != 0) begin
			pix_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix       <= p;
		pix_valid <= 1'b1;
		@(posedge clk);
		while (pix_stall)
			@(posedge clk);
		if (centroid_step(p, due))
			centroid_due.push_back(typed ? want : due);
	endtask

	// Stops sending and waits until every frame result is back and the
	// divider has had time to finish.
	task automatic settle();
		pix_valid <= 1'b0;
		@(posedge clk);
		while (centroid_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [cbc_pkg::CFG_IDX_W-1:0] idx,
	                         input logic [cbc_pkg::LWIDTH_W-1:0] val);
		settle();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			cbc_pkg::CFG_BLUE_MIN:   thr_blue  = val[cbc_pkg::LEVEL_W-1:0];
			cbc_pkg::CFG_GREEN_MAX:  thr_green = val[cbc_pkg::LEVEL_W-1:0];
			cbc_pkg::CFG_RED_MAX:    thr_red   = val[cbc_pkg::LEVEL_W-1:0];
			cbc_pkg::CFG_LINE_WIDTH: row_len   = val;
			default: ;
		endcase
	endtask

	// Picks a level at or just beside a threshold, or a random level.
	function automatic logic [cbc_pkg::LEVEL_W-1:0] near(
		input logic [cbc_pkg::LEVEL_W-1:0] v);
		case ($urandom_range(0, 3))
			0: return v;
			1: return v + 8'd1;
			2: return v - 8'd1;
			default: return 8'($urandom);
		endcase
	endfunction

	// A pixel aimed at the match window where the thresholds leave one,
	// otherwise levels clustered around the thresholds.
	function automatic cbc_pkg::pixel_t make_pixel(input bit aim);
		cbc_pkg::pixel_t p;
		p = '0;
		if (aim && thr_blue != 8'hFF && thr_green != 0 && thr_red != 0) begin
			p.blue_level  = 8'($urandom_range(255, int'(thr_blue) + 1));
			p.green_level = 8'($urandom_range(int'(thr_green) - 1, 0));
			p.red_level   = 8'($urandom_range(int'(thr_red) - 1, 0));
		end else begin
			p.blue_level  = near(thr_blue);
			p.green_level = near(thr_green);
			p.red_level   = near(thr_red);
		end
		return p;
	endfunction

	task automatic send_frame(input int len, input int density);
		cbc_pkg::pixel_t  p;
		cbc_pkg::result_t none;
		none = '0;
		for (int k = 0; k < len; k++) begin
			p = make_pixel($urandom_range(0, 99) < density);
			p.frame_end = (k == len - 1);
			send_pixel(p, 1'b0, none);
		end
	endtask

	function automatic logic [cbc_pkg::LWIDTH_W-1:0] level_setting();
		case ($urandom_range(0, 5))
			0: return {3'($urandom), 8'h00};
			1: return {3'($urandom), 8'hFF};
			default: return 11'($urandom);
		endcase
	endfunction

	function automatic logic [cbc_pkg::LWIDTH_W-1:0] width_setting();
		case ($urandom_range(0, 11))
			0: return 11'd0;
			1: return 11'd1;
			2: return 11'd1024;
			3: return 11'($urandom_range(1025, 2047));
			4: return 11'd640;
			default: return 11'($urandom_range(2, 8));
		endcase
	endfunction

	function automatic script_row_t px_row(input logic [7:0] b, input logic [7:0] g,
	                                       input logic [7:0] r, input bit fe);
		script_row_t row;
		row.kind    = STEP_PIXEL;
		row.px      = '{blue_level: b, green_level: g, red_level: r, frame_end: fe};
		row.reg_idx = cbc_pkg::CFG_BLUE_MIN;
		row.reg_val = '0;
		row.typed   = 1'b0;
		row.want    = '0;
		return row;
	endfunction

	function automatic script_row_t px_want(input logic [7:0] b, input logic [7:0] g,
	                                        input logic [7:0] r, input bit fe,
	                                        input logic [9:0] x, input logic [9:0] y,
	                                        input logic [20:0] n, input bit f);
		script_row_t row;
		row       = px_row(b, g, r, fe);
		row.typed = 1'b1;
		row.want  = '{center_x: x, center_y: y, match_count: n, found: f};
		return row;
	endfunction

	function automatic script_row_t wr_row(input logic [cbc_pkg::CFG_IDX_W-1:0] idx,
	                                       input logic [cbc_pkg::LWIDTH_W-1:0] val);
		script_row_t row;
		row         = px_row(8'd0, 8'd0, 8'd0, 1'b0);
		row.kind    = STEP_WRITE;
		row.reg_idx = idx;
		row.reg_val = val;
		return row;
	endfunction

	initial begin
		script_row_t script [$];
		int          rand_pixels;
		int          len;
		int          eff;
		int          density;

		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = cbc_pkg::CFG_BLUE_MIN;
		cfg_data  = '0;
		pix       = '0;
		pix_valid = 1'b0;
		thr_blue  = cbc_pkg::BLUE_MIN_RST;
		thr_green = cbc_pkg::GREEN_MAX_RST;
		thr_red   = cbc_pkg::RED_MAX_RST;
		row_len   = cbc_pkg::LINE_WIDTH_RST;
		clear_tracks();

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Scripted opening, starting from the reset thresholds.
		script = '{
			// A lone matching pixel at the origin.
			px_want(8'd151, 8'd99, 8'd99, 1'b1, 10'd0, 10'd0, 21'd1, 1'b1),
			// Each level exactly on its threshold fails the strict test.
			px_want(8'd150, 8'd0, 8'd0, 1'b1, 10'd0, 10'd0, 21'd0, 1'b0),
			px_want(8'd255, 8'd100, 8'd0, 1'b1, 10'd0, 10'd0, 21'd0, 1'b0),
			px_want(8'd255, 8'd0, 8'd100, 1'b1, 10'd0, 10'd0, 21'd0, 1'b0),
			px_row(8'd255, 8'd255, 8'd255, 1'b0),
			px_row(8'd200, 8'd50, 8'd50, 1'b0),
			px_row(8'd200, 8'd50, 8'd50, 1'b1),
			// Widest window, and a zero width that behaves as one pixel.
			wr_row(cbc_pkg::CFG_BLUE_MIN, 11'd0),
			wr_row(cbc_pkg::CFG_GREEN_MAX, 11'd255),
			wr_row(cbc_pkg::CFG_RED_MAX, 11'd255),
			wr_row(cbc_pkg::CFG_LINE_WIDTH, 11'd0),
			px_row(8'd255, 8'd254, 8'd254, 1'b0),
			px_row(8'd1, 8'd0, 8'd0, 1'b0),
			px_row(8'd0, 8'd0, 8'd0, 1'b0),
			px_row(8'd128, 8'd255, 8'd0, 1'b0),
			px_row(8'd128, 8'd127, 8'd127, 1'b1),
			// Width above the longest line, then lowered mid-frame so the
			// current column already lies past the new end of the line.
			wr_row(cbc_pkg::CFG_LINE_WIDTH, 11'd2047),
			px_row(8'd255, 8'd0, 8'd0, 1'b0),
			px_row(8'd255, 8'd0, 8'd0, 1'b0),
			px_row(8'd255, 8'd0, 8'd0, 1'b0),
			wr_row(cbc_pkg::CFG_LINE_WIDTH, 11'd2),
			px_row(8'd255, 8'd0, 8'd0, 1'b0),
			px_row(8'd255, 8'd0, 8'd0, 1'b0),
			px_row(8'd255, 8'd0, 8'd0, 1'b1),
			// Closed window: nothing can match.
			wr_row(cbc_pkg::CFG_LINE_WIDTH, 11'd1024),
			wr_row(cbc_pkg::CFG_BLUE_MIN, 11'd255),
			wr_row(cbc_pkg::CFG_GREEN_MAX, 11'd0),
			wr_row(cbc_pkg::CFG_RED_MAX, 11'd0),
			px_want(8'd255, 8'd0, 8'd0, 1'b1, 10'd0, 10'd0, 21'd0, 1'b0)
		};
		foreach (script[i]) begin
			if (script[i].kind == STEP_WRITE)
				write_reg(script[i].reg_idx, script[i].reg_val);
			else
				send_pixel(script[i].px, script[i].typed, script[i].want);
		end

		// A frame one pixel wide, so that every pixel opens a new row. Driving
		// the row position to its top value, or saturating the count and the
		// sums, would take far more pixels than this run sends and is left out.
		write_reg(cbc_pkg::CFG_BLUE_MIN, 11'd100);
		write_reg(cbc_pkg::CFG_GREEN_MAX, 11'd200);
		write_reg(cbc_pkg::CFG_RED_MAX, 11'd200);
		write_reg(cbc_pkg::CFG_LINE_WIDTH, 11'd1);
		send_frame(16, 50);

		// Random phases: new register settings, then a handful of frames.
		// Narrow images are mostly sent as whole rows, sometimes several; others
		// are cut short at a random length.
		rand_pixels = 0;
		while (rand_pixels < RANDOM_PIXELS) begin
			if ($urandom_range(0, 3) != 0)
				write_reg(cbc_pkg::CFG_BLUE_MIN, level_setting());
			if ($urandom_range(0, 3) != 0)
				write_reg(cbc_pkg::CFG_GREEN_MAX, level_setting());
			if ($urandom_range(0, 3) != 0)
				write_reg(cbc_pkg::CFG_RED_MAX, level_setting());
			if ($urandom_range(0, 2) != 0)
				write_reg(cbc_pkg::CFG_LINE_WIDTH, width_setting());
			repeat ($urandom_range(3, 6)) begin
				eff = line_eff();
				if ($urandom_range(0, 9) < 2)
					len = $urandom_range(1, 12);
				else if (eff <= 16)
					len = eff * $urandom_range(1, 3);
				else
					len = $urandom_range(1, 40);
				if (len > RANDOM_PIXELS - rand_pixels)
					len = RANDOM_PIXELS - rand_pixels;
				case ($urandom_range(0, 4))
					0: density = 0;
					1: density = 100;
					2: density = 25;
					default: density = 60;
				endcase
				if (len != 0)
					send_frame(len, density);
				rand_pixels += len;
			end
		end

		settle();
		if (err_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
